// ----- src/dns_name_decompressor_unit_defines.svh -----
// assertion macros shared by the dns name decompressor sources
`ifndef DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH
`define DNS_NAME_DECOMPRESSOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DND_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DND_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dnd_pkg.sv -----
// types and constants shared by the dns name decompressor modules
package dnd_pkg;

    // wide enough for a 14-bit pointer target plus one step past the store end
    localparam int CUR_W = 15;
    localparam int REM_W = 16;
    localparam logic [7:0] PTR_MARK = 8'hc0;
    localparam logic [7:0] DOT_CHAR = 8'h2e;

    // request kinds carried on the request side tuser
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_JUMPS  = 2'd1,
        ST_LONG   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REM_HOLD,
        REM_LOAD,
        REM_DEC,
        REM_SUB
    } rem_op_t;

    typedef enum logic {
        OUT_CHAR,
        OUT_WORD
    } out_kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic      load_wr;
        logic      start;
        logic      rd;
        logic      hi_cap;
        rem_op_t   rem_op;
        logic      lab_load;
        logic      dot_wr;
        logic      ch_wr;
        logic      ptr_cap;
        logic      jump;
        logic      err_set;
        status_t   err_code;
        logic      k_clr;
        logic      txt_rd;
        logic      k_inc;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic cur_ok;
        logic in_place;
        logic rem_zero;
        logic byte_zero;
        logic byte_ptr;
        logic n_zero;
        logic n_full;
        logic lab_zero;
        logic jumps_max;
        logic k_last;
        logic out_free;
    } stat_t;

endpackage

// ----- src/dns_name_decompressor_unit.sv -----
// top level of the dns name decompressor: controller plus datapath
// loads write one message byte per request; a decode request reads the two-byte
// record data length, then walks the store with one registered read port, with
// a read for each label length byte, each character and each byte of a compression
// pointer; the name is then sent from the buffer one character per result (a single
// result word for an empty name or an error), and the sink can stall it; the single
// store read port sets the walk rate and one decode is in flight at a time, while
// the last result may still wait in the output register as the next request is
// taken
module dns_name_decompressor_unit #(
    parameter int MSG_DEPTH      = 512,
    parameter int MAX_NAME_CHARS = 64,
    parameter int MAX_JUMPS      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // position [8:0], load_byte [16:9], zero pad
    input  logic        s_axis_tuser,   // mode: 0 load byte, 1 decode name
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // name_char [7:0]
    output logic [2:0]  m_axis_tuser,   // char_valid [0], status [2:1]
    output logic        m_axis_tlast    // last result of a decode
);
    import dnd_pkg::*;

    cmd_t       cmd;
    stat_t      st;
    logic       in_fire;
    logic       out_cvalid;
    logic [1:0] out_status;

    // a request only counts when the controller is idle
    assign in_fire = s_axis_tvalid && s_axis_tready;

    dnd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dnd_datapath #(
        .MSG_DEPTH      (MSG_DEPTH),
        .MAX_NAME_CHARS (MAX_NAME_CHARS),
        .MAX_JUMPS      (MAX_JUMPS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .in_position    (s_axis_tdata[8:0]),
        .in_load_byte   (s_axis_tdata[16:9]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_name_char  (m_axis_tdata),
        .out_char_valid (out_cvalid),
        .out_last       (m_axis_tlast),
        .out_status     (out_status)
    );

    assign m_axis_tuser = {out_status, out_cvalid};

    // load and decode commands fire only with an accepted request
    `DND_ASSERT_IMP(a_load_on_fire, cmd.load_wr, in_fire && !s_axis_tuser, "load without request")
    `DND_ASSERT_IMP(a_start_on_fire, cmd.start, in_fire && s_axis_tuser, "decode without request")

endmodule

// ----- src/dnd_ctrl.sv -----
// controller state machine for the dns name walk and result emission
`include "dns_name_decompressor_unit_defines.svh"

module dnd_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    input  dnd_pkg::stat_t st,
    output dnd_pkg::cmd_t  cmd
);
    import dnd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HI_RD,
        S_HI_USE,
        S_LO_RD,
        S_LO_USE,
        S_LEN_CHK,
        S_LEN_USE,
        S_CH_RD,
        S_CH_USE,
        S_PTR_RD,
        S_PTR_USE,
        S_DONE,
        S_RESULT,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == MODE_DECODE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_HI_RD;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_HI_RD, S_LO_RD:
            begin
                if (!st.cur_ok)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_RANGE;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = (state_reg == S_HI_RD) ? S_HI_USE : S_LO_USE;
                end
            end
            S_HI_USE:
            begin
                cmd.hi_cap = 1'b1;
                state_next = S_LO_RD;
            end
            S_LO_USE:
            begin
                cmd.rem_op = REM_LOAD;
                state_next = S_LEN_CHK;
            end
            S_LEN_CHK:
            begin
                if (st.in_place && st.rem_zero)
                begin
                    state_next = S_DONE;
                end
                else if (!st.cur_ok)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_RANGE;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.rem_op = REM_DEC;
                    state_next = S_LEN_USE;
                end
            end
            S_LEN_USE:
            begin
                if (st.byte_zero)
                begin
                    state_next = S_DONE;
                end
                else if (st.byte_ptr)
                begin
                    cmd.ptr_cap = 1'b1;
                    state_next  = S_PTR_RD;
                end
                else if (!st.n_zero && st.n_full)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_LONG;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.dot_wr   = !st.n_zero;
                    cmd.lab_load = 1'b1;
                    cmd.rem_op   = REM_SUB;
                    state_next   = S_CH_RD;
                end
            end
            S_CH_RD:
            begin
                if (st.lab_zero)
                begin
                    state_next = S_LEN_CHK;
                end
                else if (st.n_full)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_LONG;
                    state_next   = S_RESULT;
                end
                else if (!st.cur_ok)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_RANGE;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CH_USE;
                end
            end
            S_CH_USE:
            begin
                cmd.ch_wr  = 1'b1;
                state_next = S_CH_RD;
            end
            S_PTR_RD:
            begin
                if (!st.cur_ok)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_RANGE;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.rem_op = REM_DEC;
                    state_next = S_PTR_USE;
                end
            end
            S_PTR_USE:
            begin
                if (st.jumps_max)
                begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = ST_JUMPS;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.jump   = 1'b1;
                    state_next = S_LEN_CHK;
                end
            end
            S_DONE:
            begin
                if (st.n_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            S_RESULT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_WORD;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.txt_rd = 1'b1;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_CHAR;
                    cmd.k_inc    = 1'b1;
                    state_next   = st.k_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DND_ASSERT_IMP(a_rd_in_range, cmd.rd, st.cur_ok, "store read outside message")
    `DND_ASSERT_IMP(a_txt_not_full, cmd.ch_wr || cmd.dot_wr, !st.n_full, "name buffer overrun")
    `DND_ASSERT_IMP(a_out_free, cmd.out_load, st.out_free, "result register overwritten")
    `DND_ASSERT_IMP(a_jump_bound, cmd.jump, !st.jumps_max, "pointer followed past bound")
    `DND_ASSERT_NXT(a_start_walk, cmd.start, state_reg == S_HI_RD, "decode did not start")

endmodule

// ----- src/dnd_datapath.sv -----
// datapath: message store, walk registers, name buffer and result register
module dnd_datapath #(
    parameter int MSG_DEPTH      = 512,
    parameter int MAX_NAME_CHARS = 64,
    parameter int MAX_JUMPS      = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dnd_pkg::cmd_t  cmd,
    output dnd_pkg::stat_t st,
    input  logic [8:0]     in_position,
    input  logic [7:0]     in_load_byte,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_name_char,
    output logic           out_char_valid,
    output logic           out_last,
    output logic [1:0]     out_status
);
    import dnd_pkg::*;

    localparam int AW = $clog2(MSG_DEPTH);
    localparam int NW = $clog2(MAX_NAME_CHARS + 1);
    localparam int TW = $clog2(MAX_NAME_CHARS);
    localparam int JW = $clog2(MAX_JUMPS + 1);

    logic [7:0]       store_mem [MSG_DEPTH];
    logic [7:0]       text_mem  [MAX_NAME_CHARS];

    logic [CUR_W-1:0] cur_reg;
    logic [REM_W-1:0] rem_reg;
    logic [7:0]       hi_reg;
    logic [7:0]       rd_q_reg;
    logic [7:0]       lab_reg;
    logic [5:0]       ptr_hi_reg;
    logic [NW-1:0]    n_reg;
    logic [TW-1:0]    k_reg;
    logic [JW-1:0]    jumps_reg;
    logic             in_place_reg;
    status_t          status_reg;
    logic [7:0]       txt_q_reg;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_cvalid_reg;
    logic             out_last_reg;
    logic [1:0]       out_status_reg;

    logic [CUR_W-1:0] load_addr;
    logic             load_ok;
    logic [REM_W-1:0] byte_ext;
    logic [7:0]       txt_wdata;

    assign load_addr = CUR_W'(in_position);
    assign load_ok   = load_addr < CUR_W'(MSG_DEPTH);
    assign byte_ext  = REM_W'(rd_q_reg);
    assign txt_wdata = cmd.dot_wr ? DOT_CHAR : rd_q_reg;

    assign st.cur_ok    = cur_reg < CUR_W'(MSG_DEPTH);
    assign st.in_place  = in_place_reg;
    assign st.rem_zero  = (rem_reg == '0);
    assign st.byte_zero = (rd_q_reg == 8'd0);
    assign st.byte_ptr  = ((rd_q_reg & PTR_MARK) == PTR_MARK);
    assign st.n_zero    = (n_reg == '0);
    assign st.n_full    = (n_reg >= NW'(MAX_NAME_CHARS));
    assign st.lab_zero  = (lab_reg == 8'd0);
    assign st.jumps_max = (jumps_reg == JW'(MAX_JUMPS));
    assign st.k_last    = ((NW'(k_reg) + NW'(1)) == n_reg);
    assign st.out_free  = !out_valid_reg || out_ready;

    // byte store and name buffer, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
        begin
            store_mem[load_addr[AW-1:0]] <= in_load_byte;
        end
        if (cmd.rd)
        begin
            rd_q_reg <= store_mem[cur_reg[AW-1:0]];
        end
        if (cmd.ch_wr || cmd.dot_wr)
        begin
            text_mem[n_reg[TW-1:0]] <= txt_wdata;
        end
        if (cmd.txt_rd)
        begin
            txt_q_reg <= text_mem[k_reg];
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_reg <= load_addr;
        end
        else if (cmd.jump)
        begin
            cur_reg <= {1'b0, ptr_hi_reg, rd_q_reg};
        end
        else if (cmd.rd)
        begin
            cur_reg <= cur_reg + CUR_W'(1);
        end

        if (cmd.hi_cap)
        begin
            hi_reg <= rd_q_reg;
        end
        if (cmd.ptr_cap)
        begin
            ptr_hi_reg <= rd_q_reg[5:0];
        end

        case (cmd.rem_op)
            REM_LOAD:
            begin
                rem_reg <= {hi_reg, rd_q_reg};
            end
            REM_DEC:
            begin
                if (in_place_reg && rem_reg != '0)
                begin
                    rem_reg <= rem_reg - REM_W'(1);
                end
            end
            REM_SUB:
            begin
                if (in_place_reg)
                begin
                    rem_reg <= (rem_reg > byte_ext) ? rem_reg - byte_ext : '0;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase

        if (cmd.lab_load)
        begin
            lab_reg <= rd_q_reg;
        end
        else if (cmd.ch_wr)
        begin
            lab_reg <= lab_reg - 8'd1;
        end

        if (cmd.start)
        begin
            n_reg        <= '0;
            jumps_reg    <= '0;
            in_place_reg <= 1'b1;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (cmd.ch_wr || cmd.dot_wr)
            begin
                n_reg <= n_reg + NW'(1);
            end
            if (cmd.jump)
            begin
                jumps_reg    <= jumps_reg + JW'(1);
                in_place_reg <= 1'b0;
            end
            if (cmd.err_set)
            begin
                status_reg <= cmd.err_code;
            end
        end

        if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + TW'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_kind == OUT_CHAR)
            begin
                out_char_reg   <= txt_q_reg;
                out_cvalid_reg <= 1'b1;
                out_last_reg   <= st.k_last;
                out_status_reg <= ST_OK;
            end
            else
            begin
                out_char_reg   <= 8'd0;
                out_cvalid_reg <= 1'b0;
                out_last_reg   <= 1'b1;
                out_status_reg <= status_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_name_char  = out_char_reg;
    assign out_char_valid = out_cvalid_reg;
    assign out_last       = out_last_reg;
    assign out_status     = out_status_reg;

endmodule
